// ===== hdl/dbld_pkg.sv =====
package dbld_pkg;

	// Number of cells per battery in one sample.
	localparam int unsigned CELLS = 4;

	localparam int unsigned MV_W = 16;
	localparam int unsigned HYST_W = 10;
	localparam int unsigned CNT_W = $clog2(CELLS + 1);
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [MV_W-1:0] CELL_MIN_MV = MV_W'(2800);
	localparam logic [MV_W-1:0] CELL_MAX_MV = MV_W'(4500);

	localparam logic [MV_W-1:0] LOW_THRESH_RST = MV_W'(3300);
	localparam logic [HYST_W-1:0] HYST_RST = HYST_W'(100);

	// A battery is connected when at least half its cells read in range.
	localparam logic [CNT_W-1:0] CONNECT_MIN = CNT_W'(CELLS / 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CELLS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THRESH = CFG_IDX_W'(0),
		REG_HYST = CFG_IDX_W'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic [MV_W-1:0] low_thresh_mv;
		logic [HYST_W-1:0] hyst_mv;
	} cfg_t;

	typedef struct packed {
		logic combined_low;
		logic first_connected;
		logic second_connected;
	} result_t;

endpackage

// ===== hdl/dbld_cfg_regs.sv =====
module dbld_cfg_regs
	import dbld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MV_W-1:0]      cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Writes to an index outside the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thresh_mv <= LOW_THRESH_RST;
			cfg_q.hyst_mv <= HYST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOW_THRESH: cfg_q.low_thresh_mv <= cfg_data;
				REG_HYST: cfg_q.hyst_mv <= cfg_data[HYST_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/dbld_accum.sv =====
module dbld_accum
	import dbld_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cell_valid,
	output logic            cell_stall,
	input  logic [MV_W-1:0] cell_mv,
	input  logic            battery_sel,
	input  logic            last_cell,
	input  cfg_t            cfg,
	input  logic            res_ready,
	output logic            res_valid,
	output result_t         res
);

	logic            valid_s1;
	logic [MV_W-1:0] cell_mv_s1;
	logic            battery_sel_s1;
	logic            last_cell_s1;

	logic             low_state_q;
	logic [CNT_W-1:0] cnt_first_q, cnt_second_q;
	logic             any_low_first_q, any_low_second_q;

	logic             fire;
	logic             accept;
	logic [MV_W:0]    thresh_sum;
	logic [MV_W-1:0]  thresh_act;
	logic             in_range, is_low;
	logic [CNT_W-1:0] cnt_first_nxt, cnt_second_nxt;
	logic             any_low_first_nxt, any_low_second_nxt;
	logic             conn_first, conn_second, low_nxt;

	// A last cell leaves stage 1 only when the result register can take it.
	assign fire = valid_s1 && (!last_cell_s1 || res_ready);
	assign cell_stall = valid_s1 && !fire;
	assign accept = cell_valid && !cell_stall;

	always_comb begin
		thresh_sum = {1'b0, cfg.low_thresh_mv} + (MV_W + 1)'(cfg.hyst_mv);
		if (!low_state_q) begin
			thresh_act = cfg.low_thresh_mv;
		end else if (thresh_sum[MV_W]) begin
			thresh_act = '1;
		end else begin
			thresh_act = thresh_sum[MV_W-1:0];
		end

		in_range = (cell_mv_s1 >= CELL_MIN_MV) && (cell_mv_s1 <= CELL_MAX_MV);
		is_low = cell_mv_s1 < thresh_act;

		cnt_first_nxt = cnt_first_q;
		cnt_second_nxt = cnt_second_q;
		any_low_first_nxt = any_low_first_q;
		any_low_second_nxt = any_low_second_q;
		if (battery_sel_s1) begin
			if (in_range && (cnt_second_q < CNT_MAX)) begin
				cnt_second_nxt = cnt_second_q + CNT_W'(1);
			end
			any_low_second_nxt = any_low_second_q || is_low;
		end else begin
			if (in_range && (cnt_first_q < CNT_MAX)) begin
				cnt_first_nxt = cnt_first_q + CNT_W'(1);
			end
			any_low_first_nxt = any_low_first_q || is_low;
		end

		conn_first = cnt_first_nxt >= CONNECT_MIN;
		conn_second = cnt_second_nxt >= CONNECT_MIN;
		priority if (conn_first && conn_second) begin
			low_nxt = any_low_first_nxt && any_low_second_nxt;
		end else if (conn_first) begin
			low_nxt = any_low_first_nxt;
		end else if (conn_second) begin
			low_nxt = any_low_second_nxt;
		end else begin
			low_nxt = 1'b0;
		end
	end

	assign res_valid = fire && last_cell_s1;
	assign res.combined_low = low_nxt;
	assign res.first_connected = conn_first;
	assign res.second_connected = conn_second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_mv_s1 <= cell_mv;
			battery_sel_s1 <= battery_sel;
			last_cell_s1 <= last_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_state_q <= 1'b0;
			cnt_first_q <= '0;
			cnt_second_q <= '0;
			any_low_first_q <= 1'b0;
			any_low_second_q <= 1'b0;
		end else if (fire) begin
			if (last_cell_s1) begin
				low_state_q <= low_nxt;
				cnt_first_q <= '0;
				cnt_second_q <= '0;
				any_low_first_q <= 1'b0;
				any_low_second_q <= 1'b0;
			end else begin
				cnt_first_q <= cnt_first_nxt;
				cnt_second_q <= cnt_second_nxt;
				any_low_first_q <= any_low_first_nxt;
				any_low_second_q <= any_low_second_nxt;
			end
		end
	end

endmodule

// ===== hdl/dbld_out_reg.sv =====
module dbld_out_reg
	import dbld_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    res_ready,
	output logic    result_valid,
	input  logic    result_stall,
	output logic    combined_low,
	output logic    first_connected,
	output logic    second_connected
);

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign combined_low = res_q.combined_low;
	assign first_connected = res_q.first_connected;
	assign second_connected = res_q.second_connected;

endmodule

// ===== hdl/dual_battery_low_detector.sv =====
// A last cell is held in stage 1, and its result is then registered in the result
// register, from which it is offered on the result ports.
// Throughput: one cell per cycle; the result register frees itself in the cycle
// it is taken, so a stalled result blocks input only when a last cell waits behind it.
// Reset: arst_n clears the low state, counters, valid bits and loads the register
// defaults (threshold 3300 mV, hysteresis 100 mV).
module dual_battery_low_detector
	import dbld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MV_W-1:0]      cfg_data,
	input  logic                 cell_valid,
	output logic                 cell_stall,
	input  logic [MV_W-1:0]      cell_mv,
	input  logic                 battery_sel,
	input  logic                 last_cell,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 combined_low,
	output logic                 first_connected,
	output logic                 second_connected
);

	// The configuration registers are always ready; a transfer to an index
	// outside the register list changes nothing.
	cfg_t    cfg;
	logic    res_valid;
	logic    res_ready;
	result_t res;

	dbld_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 holds one cell. Its compares and counter updates run while it
	// sits there, and the per-sample state moves on as the cell leaves. A
	// last cell also produces the connected flags and the new low state,
	// which then sets the threshold for the next cell behind it.
	dbld_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.cell_mv     (cell_mv),
		.battery_sel (battery_sel),
		.last_cell   (last_cell),
		.cfg         (cfg),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	// The result register parts the input side from the result channel.
	dbld_out_reg u_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.res_valid        (res_valid),
		.res              (res),
		.res_ready        (res_ready),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.combined_low     (combined_low),
		.first_connected  (first_connected),
		.second_connected (second_connected)
	);

endmodule

// ===== hdl/dbld_checker.sv =====
module dbld_checker (
	input logic clk,
	input logic arst_n,
	input logic cell_stall,
	input logic result_valid,
	input logic result_stall,
	input logic combined_low,
	input logic first_connected,
	input logic second_connected
);

	// A stalled result stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(combined_low) && $stable(first_connected)
			&& $stable(second_connected))
		else $error("result changed while stalled");

	// The low state can only be set with some battery connected.
	a_low_needs_conn: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !combined_low || first_connected || second_connected)
		else $error("low battery reported with no battery connected");

	// Input backs up only behind a stalled, full result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	// No result comes straight out of reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

endmodule

bind dual_battery_low_detector dbld_checker u_dbld_checker (.*);

// ===== sim/dual_battery_low_detector_tb.sv =====
module dual_battery_low_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dbld_pkg::*;

	localparam time HALF_PERIOD = 4ns;
	localparam int RESET_CYCLES = 7;
	// Percent of cycles in which the cell sender or the result receiver holds off.
	localparam int IDLE_PCT = 10;
	// Settling cycles after the last verdict, leaving the block with nothing in flight.
	localparam int HOLD_OFF = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES = 6;
	localparam int PHASE_CELLS = 195;
	// Phase in which neither side idles at all.
	localparam int STEADY_PHASE = 3;
	// Number of defined registers; every index from here up is unused.
	localparam int REG_COUNT = 2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

	// Tracks what the block should decide for each sample of both batteries:
	// per-battery in-range counts, per-battery low flags and the combined low
	// state with its hysteresis. Expected verdicts wait in a queue in order.
	class verdict_tracker;
		logic [MV_W-1:0] low_thresh_mv;
		logic [HYST_W-1:0] hyst_mv;
		bit low_state;
		logic [CNT_W-1:0] in_range_first;
		logic [CNT_W-1:0] in_range_second;
		bit any_low_first;
		bit any_low_second;
		result_t pending[$];
		int mismatches;
		int cells;
		int verdicts;
		int reg_writes;

		function new();
			low_thresh_mv = LOW_THRESH_RST;
			hyst_mv = HYST_RST;
			low_state = 1'b0;
			in_range_first = '0;
			in_range_second = '0;
			any_low_first = 1'b0;
			any_low_second = 1'b0;
			mismatches = 0;
			cells = 0;
			verdicts = 0;
			reg_writes = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_LOW_THRESH: begin
					low_thresh_mv = data;
				end
				REG_HYST: begin
					hyst_mv = data[HYST_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// While low, the bar to leave the low state is raised by the hysteresis,
		// clipped at the top of the millivolt range.
		function logic [MV_W-1:0] active_thresh();
			logic [MV_W:0] sum;
			sum = {1'b0, low_thresh_mv};
			if (low_state)
				sum = sum + (MV_W + 1)'(hyst_mv);
			if (sum[MV_W])
				return '1;
			return sum[MV_W-1:0];
		endfunction

		function void take_cell(logic [MV_W-1:0] mv, logic sel, logic last);
			bit in_range;
			bit is_low;
			bit conn_first;
			bit conn_second;
			result_t verdict;
			cells++;
			in_range = (mv >= CELL_MIN_MV) && (mv <= CELL_MAX_MV);
			is_low = mv < active_thresh();
			if (sel) begin
				if (in_range && in_range_second < CNT_MAX)
					in_range_second++;
				if (is_low)
					any_low_second = 1'b1;
			end else begin
				if (in_range && in_range_first < CNT_MAX)
					in_range_first++;
				if (is_low)
					any_low_first = 1'b1;
			end
			if (!last)
				return;
			conn_first = in_range_first >= CONNECT_MIN;
			conn_second = in_range_second >= CONNECT_MIN;
			if (conn_first && conn_second)
				low_state = any_low_first && any_low_second;
			else if (conn_first)
				low_state = any_low_first;
			else if (conn_second)
				low_state = any_low_second;
			else
				low_state = 1'b0;
			verdict.combined_low = low_state;
			verdict.first_connected = conn_first;
			verdict.second_connected = conn_second;
			pending.push_back(verdict);
			in_range_first = '0;
			in_range_second = '0;
			any_low_first = 1'b0;
			any_low_second = 1'b0;
		endfunction

		function void check_verdict(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result: combined_low=%0b first_connected=%0b %s%0b",
					got.combined_low, got.first_connected, "second_connected=",
					got.second_connected);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			verdicts++;
			if (got.combined_low !== want.combined_low) begin
				$error("combined_low: expected %0b, got %0b",
					want.combined_low, got.combined_low);
				mismatches++;
			end
			if (got.first_connected !== want.first_connected) begin
				$error("first_connected: expected %0b, got %0b",
					want.first_connected, got.first_connected);
				mismatches++;
			end
			if (got.second_connected !== want.second_connected) begin
				$error("second_connected: expected %0b, got %0b",
					want.second_connected, got.second_connected);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MV_W-1:0] cfg_data;
	logic cell_valid;
	logic cell_stall;
	logic [MV_W-1:0] cell_mv;
	logic battery_sel;
	logic last_cell;
	logic result_valid;
	logic result_stall;
	logic combined_low;
	logic first_connected;
	logic second_connected;

	verdict_tracker tracker;
	// When set, neither the cell sender nor the result receiver holds off.
	bit steady;
	int quiet_cycles;

	dual_battery_low_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_mv(cell_mv),
		.battery_sel(battery_sel),
		.last_cell(last_cell),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.combined_low(combined_low),
		.first_connected(first_connected),
		.second_connected(second_connected)
	);

	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	// The result receiver stalls at random on about one cycle in ten. The stall
	// changes only at falling edges so that it is stable at every rising edge.
	always @(negedge clk) begin
		result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Everything that crosses a port is observed here at the rising edge. A cell
	// transfer feeds the tracker, a result transfer is checked against the oldest
	// verdict, and a register write updates the tracker's copy of the settings.
	// The same block watches for a stuck run: too many cycles in a row without
	// any transfer at all end the run as failed.
	always @(posedge clk) begin
		if (cell_valid && !cell_stall)
			tracker.take_cell(cell_mv, battery_sel, last_cell);
		if (result_valid && !result_stall)
			tracker.check_verdict(result_t'{combined_low, first_connected, second_connected});
		if (cfg_valid && cfg_ready)
			tracker.write_reg(cfg_index, cfg_data);
		if (!arst_n || (cell_valid && !cell_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Starts at a falling edge and returns at the falling edge after the write
	// transfer, leaving cfg_valid high. The caller lowers it once the batch of
	// writes is done, so valid is never dropped and raised in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// Sends one cell. The sender may first hold off at random with valid
	// low. Once valid is raised the payload is held until the transfer happens.
	// The task returns at the following falling edge with valid still high, so
	// the next cell can follow back to back.
	task automatic send_cell(input logic [MV_W-1:0] mv, input logic sel, input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cell_valid <= 1'b0;
			@(negedge clk);
		end
		cell_valid <= 1'b1;
		cell_mv <= mv;
		battery_sel <= sel;
		last_cell <= last;
		do
			@(posedge clk);
		while (cell_stall);
		@(negedge clk);
	endtask

	// Picks a cell voltage. Half the values sit in the plausible range or close to
	// the current threshold so that the hysteresis window gets exercised; the
	// rest are range boundaries, values below the range and anything at all.
	function automatic logic [MV_W-1:0] pick_mv();
		int roll;
		int lo;
		int hi;
		roll = $urandom_range(99);
		if (roll < 30)
			return MV_W'($urandom_range(CELL_MAX_MV, CELL_MIN_MV));
		if (roll < 50) begin
			lo = int'(tracker.low_thresh_mv) - 1200;
			hi = int'(tracker.low_thresh_mv) + 1200;
			if (lo < 0)
				lo = 0;
			if (hi > 65535)
				hi = 65535;
			return MV_W'($urandom_range(hi, lo));
		end
		if (roll < 60) begin
			case ($urandom_range(5))
				0: return CELL_MIN_MV - 1'b1;
				1: return CELL_MIN_MV;
				2: return CELL_MAX_MV;
				3: return CELL_MAX_MV + 1'b1;
				4: return '0;
				default: return '1;
			endcase
		end
		if (roll < 80)
			return MV_W'($urandom_range(CELL_MIN_MV - 1));
		return MV_W'($urandom);
	endfunction

	// Sends a group of cells for both batteries. Cells come battery by battery
	// or mixed at random, and the final cell carries the last flag if asked.
	task automatic send_sample(input int n_first, input int n_second, input bit mix,
			input bit mark_last);
		int total;
		int left_first;
		int left_second;
		logic sel;
		left_first = n_first;
		left_second = n_second;
		if (left_first + left_second == 0)
			left_first = 1;
		total = left_first + left_second;
		for (int i = 0; i < total; i++) begin
			if (left_first == 0)
				sel = 1'b1;
			else if (left_second == 0)
				sel = 1'b0;
			else if (mix)
				sel = $urandom_range(1);
			else
				sel = 1'b0;
			if (sel)
				left_second--;
			else
				left_first--;
			send_cell(pick_mv(), sel, mark_last && (i == total - 1));
		end
	endtask

	// The sender pauses until every verdict has been taken, then lets the
	// block settle. Called at a falling edge.
	task automatic settle();
		cell_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (HOLD_OFF)
			@(negedge clk);
	endtask

	initial begin
		logic [MV_W-1:0] thresh;
		logic [MV_W-1:0] hyst_word;
		int first_cell;
		int roll;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cell_valid = 1'b0;
		cell_mv = '0;
		battery_sel = 1'b0;
		last_cell = 1'b0;
		steady = 1'b0;
		tracker = new();

		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A write to an index past the register list must change nothing, so the
		// directed samples below still run on the reset thresholds.
		write_reg(REG_UNUSED, '1);
		cfg_valid <= 1'b0;

		// Both batteries connected and each has a low cell, so the combined flag
		// sets. The first battery also shows both ends of the plausible range.
		send_cell(MV_W'(3000), 1'b0, 1'b0);
		send_cell(CELL_MIN_MV, 1'b0, 1'b0);
		send_cell(CELL_MAX_MV, 1'b0, 1'b0);
		send_cell(MV_W'(4000), 1'b0, 1'b0);
		send_cell(MV_W'(3100), 1'b1, 1'b0);
		send_cell(MV_W'(4000), 1'b1, 1'b0);
		send_cell(MV_W'(4000), 1'b1, 1'b0);
		send_cell(MV_W'(4000), 1'b1, 1'b1);

		// The first battery reads nothing plausible (zero, full scale, just
		// outside both ends), so only the second one counts. Its 3350 mV cell is
		// above the plain threshold but below it plus hysteresis, which keeps the
		// low state set. The second battery also sends fewer cells than usual.
		send_cell('0, 1'b0, 1'b0);
		send_cell('1, 1'b0, 1'b0);
		send_cell(CELL_MAX_MV + 1'b1, 1'b0, 1'b0);
		send_cell(CELL_MIN_MV - 1'b1, 1'b0, 1'b0);
		send_cell(MV_W'(3350), 1'b1, 1'b0);
		send_cell(MV_W'(4000), 1'b1, 1'b0);
		send_cell(MV_W'(4000), 1'b1, 1'b1);

		// One cell too many for the first battery: its count saturates, the
		// second battery is absent, and with no low cell the flag clears.
		for (int i = 0; i <= CELLS; i++)
			send_cell(MV_W'(4000), 1'b0, i == CELLS);

		// Nothing in range on either side: no battery connected, flag clear.
		send_cell('1, 1'b1, 1'b1);
		settle();

		// Random phases, each under its own pair of settings. The first three
		// cover the extremes: nothing ever low, a threshold where the added
		// hysteresis clips at full scale, and the largest threshold.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					thresh = '0;
					hyst_word = '0;
				end
				1: begin
					thresh = MV_W'(65000);
					hyst_word = '1;
				end
				2: begin
					thresh = '1;
					hyst_word = '1;
				end
				3: begin
					thresh = MV_W'($urandom_range(CELL_MAX_MV, CELL_MIN_MV));
					hyst_word = MV_W'($urandom);
				end
				4: begin
					thresh = MV_W'($urandom);
					hyst_word = MV_W'($urandom);
				end
				default: begin
					thresh = MV_W'(3800);
					hyst_word = MV_W'($urandom);
					hyst_word[HYST_W-1:0] = '1;
				end
			endcase
			write_reg(REG_LOW_THRESH, thresh);
			write_reg(REG_HYST, hyst_word);
			if (phase % 2 == 1)
				write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_COUNT)),
					MV_W'($urandom));
			cfg_valid <= 1'b0;
			steady = (phase == STEADY_PHASE);

			// Mostly complete samples of both batteries; some broken ones with
			// too few or too many cells; a little noise that may not end a sample.
			first_cell = tracker.cells;
			while (tracker.cells - first_cell < PHASE_CELLS) begin
				roll = $urandom_range(99);
				if (roll < 75)
					send_sample(CELLS, CELLS, $urandom_range(1), 1'b1);
				else if (roll < 90)
					send_sample($urandom_range(CELLS + 2), $urandom_range(CELLS + 2), 1'b1,
						1'b1);
				else
					send_sample($urandom_range(2), $urandom_range(1), 1'b1, $urandom_range(1));
			end
			// Close the phase on a full sample so no partial counts carry over
			// into the next settings.
			send_sample(CELLS, CELLS, 1'b0, 1'b1);
			settle();
			steady = 1'b0;
		end

		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Covered %0d cells over %0d threshold settings with %0d register writes;",
			tracker.cells, PHASES + 1, tracker.reg_writes);
		$display("%0d sample verdicts checked, %0d mismatches.",
			tracker.verdicts, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
